// File: design/mono_framebuffer_line_circle_draw_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the framebuffer rasterizer
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MONO_FRAMEBUFFER_LINE_CIRCLE_DRAW_ASSERT_SVH
`define MONO_FRAMEBUFFER_LINE_CIRCLE_DRAW_ASSERT_SVH

// Same-cycle implication
`define MFB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication
`define MFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: design/mfb_pkg.sv
// ---------------------------------------------------------------------------
// mfb_pkg
// Shared types and constants of the monochrome framebuffer rasterizer.
// ---------------------------------------------------------------------------
`default_nettype none

package mfb_pkg;

  // Default screen geometry
  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;

  // Rows held by one column byte of a page
  localparam int PAGE_ROWS = 8;

  // Signed plot coordinate: 0..255 plus or minus 0..255
  localparam int COORD_W = 10;
  // Decision term of the line and circle walks
  localparam int DEC_W = 16;
  // Width of the byte address before trimming to the store depth
  localparam int ADDR_FULL_W = 14;

  // Bresenham circle constants
  localparam int CIRC_D0    = 3;
  localparam int CIRC_INC_A = 6;
  localparam int CIRC_INC_B = 10;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_LINE   = 2'd0,
    KIND_CIRCLE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PLOT_RD,
    ST_PLOT_WR,
    ST_LINE_CALC,
    ST_LINE_STEP,
    ST_CIRC_TEST,
    ST_CIRC_PT,
    ST_CIRC_UPD,
    ST_READ_RD,
    ST_READ_BIT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// File: design/mono_framebuffer_line_circle_draw.sv
// ---------------------------------------------------------------------------
// mono_framebuffer_line_circle_draw
// Column-byte framebuffer with Bresenham line and circle drawing.
// ---------------------------------------------------------------------------
// Usage:
//   Raise start with an item on the in_ ports; it is taken at a clock edge
//   where busy is low. in_kind selects line, circle, pixel read or clear.
//   Every item gives one result: out_valid is high for exactly one cycle with
//   out_pixel_value (the pixel bit for a read, 0 otherwise). The receiver
//   cannot stall; busy stays high from the transfer until after the strobe.
// Work per item: each plotted pixel is a read-modify-write of one store byte
//   (a read state, then a write state); off-screen pixels skip both:
//   read  : one store read, none when off screen
//   line  : one plot per point on the major axis, max(|dx|, |dy|) + 1 points
//   circle: eight plots per octant step
//   clear : SCREEN_WIDTH * ceil(SCREEN_HEIGHT/8) bytes, one byte a cycle
// Reset: a clearing pass zeroes all SCREEN_WIDTH * ceil(SCREEN_HEIGHT/8) store
//   bytes (1024 at default size); busy is high meanwhile and no
//   result is given for it.
// ---------------------------------------------------------------------------
`default_nettype none

`include "mono_framebuffer_line_circle_draw_assert.svh"

module mono_framebuffer_line_circle_draw #(
  parameter int SCREEN_WIDTH  = mfb_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = mfb_pkg::DEF_SCREEN_HEIGHT
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_kind,
  input  wire logic [7:0] in_x_start,
  input  wire logic [7:0] in_y_start,
  input  wire logic [7:0] in_x_end,
  input  wire logic [7:0] in_y_end,
  input  wire logic [7:0] in_radius,
  input  wire logic       in_color,
  output logic            out_valid,
  output logic            out_pixel_value
);
  import mfb_pkg::*;

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  localparam logic signed [COORD_W-1:0] WIDTH_S  = COORD_W'(SCREEN_WIDTH);
  localparam logic signed [COORD_W-1:0] HEIGHT_S = COORD_W'(SCREEN_HEIGHT);
  localparam logic [ADDR_W-1:0]         LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

  // Sequencer registers
  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  logic   boot_r, boot_nxt;
  logic   result_r, result_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // Item registers
  logic [7:0] xs_r, xs_nxt;
  logic [7:0] ys_r, ys_nxt;
  logic [7:0] xe_r, xe_nxt;
  logic [7:0] ye_r, ye_nxt;
  logic       color_r, color_nxt;

  // Plot request
  logic signed [COORD_W-1:0] px_r, px_nxt;
  logic signed [COORD_W-1:0] py_r, py_nxt;
  logic [ADDR_W-1:0]         addr_r, addr_nxt;

  // Walk state
  logic [7:0] maj_r, maj_nxt;
  logic [7:0] mino_r, mino_nxt;
  logic [7:0] majend_r, majend_nxt;
  logic [7:0] dmaj_r, dmaj_nxt;
  logic [7:0] dmin_r, dmin_nxt;
  logic       sx_r, sx_nxt;
  logic       sy_r, sy_nxt;
  logic       swap_r, swap_nxt;
  logic signed [DEC_W-1:0]   d_r, d_nxt;
  logic signed [COORD_W-1:0] cx_r, cx_nxt;
  logic signed [COORD_W-1:0] cy_r, cy_nxt;
  logic [2:0] pt_r, pt_nxt;

  // Store
  logic [7:0]        mem [STORE_BYTES];
  logic [7:0]        rdata_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  // Address and bounds of the current plot point
  logic                   on_screen;
  logic [ADDR_FULL_W-1:0] addr_full;
  logic [ADDR_W-1:0]      addr;
  logic [7:0]             mask;

  assign on_screen = (px_r >= 0) && (px_r < WIDTH_S) && (py_r >= 0) && (py_r < HEIGHT_S);
  assign addr_full = ADDR_FULL_W'(py_r[7:3]) * ADDR_FULL_W'(SCREEN_WIDTH)
                   + ADDR_FULL_W'(px_r[7:0]);
  assign addr      = addr_full[ADDR_W-1:0];
  assign mask      = 8'(1) << py_r[2:0];

  // Store port: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[addr];
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      ret_r     <= ST_IDLE;
      boot_r    <= 1'b1;
      result_r  <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      boot_r    <= boot_nxt;
      result_r  <= result_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    xs_r     <= xs_nxt;
    ys_r     <= ys_nxt;
    xe_r     <= xe_nxt;
    ye_r     <= ye_nxt;
    color_r  <= color_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    addr_r   <= addr_nxt;
    maj_r    <= maj_nxt;
    mino_r   <= mino_nxt;
    majend_r <= majend_nxt;
    dmaj_r   <= dmaj_nxt;
    dmin_r   <= dmin_nxt;
    sx_r     <= sx_nxt;
    sy_r     <= sy_nxt;
    swap_r   <= swap_nxt;
    d_r      <= d_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    pt_r     <= pt_nxt;
  end

  // Next state and datapath
  always_comb begin
    logic [7:0] dx, dy;
    logic       swp;
    logic [7:0] amaj, amin, bmaj, bmin;
    logic [7:0] maj_step, min_step;
    logic signed [COORD_W-1:0] xc, yc, ofs_a, ofs_b;

    state_nxt   = state_r;
    ret_nxt     = ret_r;
    boot_nxt    = boot_r;
    result_nxt  = result_r;
    clr_cnt_nxt = clr_cnt_r;
    xs_nxt      = xs_r;
    ys_nxt      = ys_r;
    xe_nxt      = xe_r;
    ye_nxt      = ye_r;
    color_nxt   = color_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    addr_nxt    = addr_r;
    maj_nxt     = maj_r;
    mino_nxt    = mino_r;
    majend_nxt  = majend_r;
    dmaj_nxt    = dmaj_r;
    dmin_nxt    = dmin_r;
    sx_nxt      = sx_r;
    sy_nxt      = sy_r;
    swap_nxt    = swap_r;
    d_nxt       = d_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    pt_nxt      = pt_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = addr_r;
    mem_wdata   = color_r ? (rdata_r | mask) : (rdata_r & ~mask);

    // Line setup terms
    dx   = (xe_r >= xs_r) ? (xe_r - xs_r) : (xs_r - xe_r);
    dy   = (ye_r >= ys_r) ? (ye_r - ys_r) : (ys_r - ye_r);
    swp  = dx < dy;
    amaj = swp ? ys_r : xs_r;
    amin = swp ? xs_r : ys_r;
    bmaj = swp ? ye_r : xe_r;
    bmin = swp ? xe_r : ye_r;

    // Line step terms
    maj_step = sx_r ? (maj_r + 8'd1) : (maj_r - 8'd1);
    min_step = sy_r ? (mino_r + 8'd1) : (mino_r - 8'd1);

    // Circle point: center plus or minus the swapped offsets
    xc    = $signed({2'b00, xs_r});
    yc    = $signed({2'b00, ys_r});
    ofs_a = pt_r[2] ? cy_r : cx_r;
    ofs_b = pt_r[2] ? cx_r : cy_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          xs_nxt     = in_x_start;
          ys_nxt     = in_y_start;
          xe_nxt     = in_x_end;
          ye_nxt     = in_y_end;
          color_nxt  = in_color;
          result_nxt = 1'b0;
          px_nxt     = $signed({2'b00, in_x_start});
          py_nxt     = $signed({2'b00, in_y_start});
          unique case (kind_t'(in_kind))
            KIND_LINE: begin
              ret_nxt   = ST_LINE_CALC;
              state_nxt = ST_PLOT_RD;
            end
            KIND_CIRCLE: begin
              d_nxt     = $signed(DEC_W'(CIRC_D0)) - $signed(DEC_W'({in_radius, 1'b0}));
              cx_nxt    = '0;
              cy_nxt    = $signed({2'b00, in_radius});
              state_nxt = ST_CIRC_TEST;
            end
            KIND_READ: begin
              state_nxt = ST_READ_RD;
            end
            KIND_CLEAR: begin
              state_nxt = ST_CLEAR;
            end
          endcase
        end
      end

      // Zero one byte a cycle
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        if (clr_cnt_r == LAST_ADDR) begin
          clr_cnt_nxt = '0;
          boot_nxt    = 1'b0;
          state_nxt   = boot_r ? ST_IDLE : ST_DONE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      // Fetch the target byte, drop off-screen points
      ST_PLOT_RD: begin
        if (on_screen) begin
          mem_re    = 1'b1;
          addr_nxt  = addr;
          state_nxt = ST_PLOT_WR;
        end else begin
          state_nxt = ret_r;
        end
      end

      // Write back the byte with the pixel set or cleared
      ST_PLOT_WR: begin
        mem_we    = 1'b1;
        state_nxt = ret_r;
      end

      // Pick the major axis and seed the decision term, or finish a one-point line
      ST_LINE_CALC: begin
        if ((xs_r == xe_r) && (ys_r == ye_r)) begin
          state_nxt = ST_DONE;
        end else begin
          swap_nxt   = swp;
          maj_nxt    = amaj;
          mino_nxt   = amin;
          majend_nxt = bmaj;
          dmaj_nxt   = swp ? dy : dx;
          dmin_nxt   = swp ? dx : dy;
          sx_nxt     = bmaj > amaj;
          sy_nxt     = bmin > amin;
          d_nxt      = $signed(DEC_W'({swp ? dx : dy, 1'b0})) - $signed(DEC_W'(swp ? dy : dx));
          state_nxt  = ST_LINE_STEP;
        end
      end

      // Advance the major axis, update the term, then plot; finish at the end point
      ST_LINE_STEP: begin
        if (maj_r == majend_r) begin
          state_nxt = ST_DONE;
        end else begin
          maj_nxt = maj_step;
          if (d_r < 0) begin
            d_nxt = d_r + $signed(DEC_W'({dmin_r, 1'b0}));
            px_nxt = swap_r ? $signed({2'b00, mino_r}) : $signed({2'b00, maj_step});
            py_nxt = swap_r ? $signed({2'b00, maj_step}) : $signed({2'b00, mino_r});
          end else begin
            mino_nxt = min_step;
            d_nxt = d_r + $signed(DEC_W'({dmin_r, 1'b0})) - $signed(DEC_W'({dmaj_r, 1'b0}));
            px_nxt = swap_r ? $signed({2'b00, min_step}) : $signed({2'b00, maj_step});
            py_nxt = swap_r ? $signed({2'b00, maj_step}) : $signed({2'b00, min_step});
          end
          ret_nxt   = ST_LINE_STEP;
          state_nxt = ST_PLOT_RD;
        end
      end

      // Continue while the octant walk has not crossed the diagonal
      ST_CIRC_TEST: begin
        if (cx_r <= cy_r) begin
          pt_nxt    = '0;
          state_nxt = ST_CIRC_PT;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      // Plot one of the eight symmetric points
      ST_CIRC_PT: begin
        px_nxt    = pt_r[1] ? (xc - ofs_a) : (xc + ofs_a);
        py_nxt    = pt_r[0] ? (yc - ofs_b) : (yc + ofs_b);
        pt_nxt    = pt_r + 3'd1;
        ret_nxt   = (pt_r == 3'd7) ? ST_CIRC_UPD : ST_CIRC_PT;
        state_nxt = ST_PLOT_RD;
      end

      // Update the decision term and step the offsets
      ST_CIRC_UPD: begin
        if (d_r < 0) begin
          d_nxt = d_r + ($signed(DEC_W'(cx_r)) <<< 2) + $signed(DEC_W'(CIRC_INC_A));
        end else begin
          d_nxt = d_r + ($signed(DEC_W'(cx_r - cy_r)) <<< 2) + $signed(DEC_W'(CIRC_INC_B));
          cy_nxt = cy_r - COORD_W'(1);
        end
        cx_nxt    = cx_r + COORD_W'(1);
        state_nxt = ST_CIRC_TEST;
      end

      // Pixel read: off-screen reads give zero
      ST_READ_RD: begin
        if (on_screen) begin
          mem_re    = 1'b1;
          state_nxt = ST_READ_BIT;
        end else begin
          result_nxt = 1'b0;
          state_nxt  = ST_DONE;
        end
      end

      ST_READ_BIT: begin
        result_nxt = rdata_r[py_r[2:0]];
        state_nxt  = ST_DONE;
      end

      ST_DONE: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_DONE);
  assign out_pixel_value = result_r;

  // Checks
  `MFB_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid && !busy)
  `MFB_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `MFB_ASSERT_NOW(a_wr_after_rd, state_r == ST_PLOT_WR, $past(state_r) == ST_PLOT_RD)
  `MFB_ASSERT_NOW(a_plot_in_bounds, mem_re, on_screen)

endmodule

`default_nettype wire
